// ===== hw/rtl/rrcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Range remap package
// Shared widths, register indexes, mode bits and sideband types for the
// range remap, clamp and wrap pipeline.
// ----------------------------------------------------------------------------
package rrcw_pkg;

  // Fixed-point format and derived widths.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SPAN_W    = DATA_W + 1;
  localparam int unsigned Q_W       = FRAC_BITS + 1;
  localparam int unsigned NUM_W     = DATA_W + FRAC_BITS + 1;
  localparam int unsigned PROD_W    = Q_W + 1 + SPAN_W;
  localparam int unsigned SH_W      = PROD_W - FRAC_BITS;
  localparam int unsigned RES_W     = SH_W + 1;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned MODE_W    = 4;

  // Fraction value of one.
  localparam logic [Q_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Mode register bit positions.
  localparam int unsigned MODE_CLAMP_LO = 0;
  localparam int unsigned MODE_CLAMP_HI = 1;
  localparam int unsigned MODE_WRAP     = 2;
  localparam int unsigned MODE_REVERSE  = 3;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_IN  = 3'd0,
    REG_MAX_IN  = 3'd1,
    REG_MIN_OUT = 3'd2,
    REG_MAX_OUT = 3'd3,
    REG_MODE    = 3'd4,
    REG_HOLD    = 3'd5
  } reg_idx_e;

  // Sideband that travels beside the remainder divider.
  typedef struct packed {
    logic                     is_num;
    logic                     eq_out;
    logic                     neg_v;
    logic                     need_wrap;
    logic signed [DATA_W-1:0] v1;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo_out;
    logic signed [DATA_W-1:0] hi_out;
    logic signed [SPAN_W-1:0] span;
  } rem_side_t;

  // Sideband that travels beside the fraction divider.
  typedef struct packed {
    logic                     is_num;
    logic                     eq_out;
    logic                     below;
    logic                     above;
    logic                     span_zero;
    logic                     num_pos;
    logic signed [DATA_W-1:0] lo_out;
    logic signed [DATA_W-1:0] hi_out;
  } frac_side_t;

endpackage

// ===== hw/rtl/rrcw_rem_div.sv =====
// ----------------------------------------------------------------------------
// Remainder divider
// Pipelined restoring division, one dividend bit per stage, that yields
// the unsigned remainder of the value magnitude by the span magnitude.
// ----------------------------------------------------------------------------
module rrcw_rem_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rrcw_pkg::DATA_W-1:0]    dividend_i,
  input  logic [rrcw_pkg::DATA_W-1:0]    divisor_i,
  input  rrcw_pkg::rem_side_t            side_i,
  output logic                           valid_o,
  output logic [rrcw_pkg::DATA_W-1:0]    rem_o,
  output rrcw_pkg::rem_side_t            side_o
);
  import rrcw_pkg::*;

  localparam int unsigned NSTG = DATA_W;

  logic              valid_q [NSTG];
  logic [DATA_W-1:0] rem_q   [NSTG];
  logic [DATA_W-1:0] dvd_q   [NSTG];
  logic [DATA_W-1:0] dsr_q   [NSTG];
  rem_side_t         side_q  [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic              v_in;
    logic [DATA_W-1:0] r_in;
    logic [DATA_W-1:0] dvd_in;
    logic [DATA_W-1:0] dsr_in;
    rem_side_t         s_in;
    logic [DATA_W:0]   r_shift;
    logic [DATA_W:0]   r_diff;
    logic [DATA_W-1:0] r_d;

    // Stage inputs come from the ports or from the previous stage.
    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign r_in   = '0;
      assign dvd_in = dividend_i;
      assign dsr_in = divisor_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign r_in   = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign s_in   = side_q[k-1];
    end

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign r_shift = {r_in, dvd_in[DATA_W-1]};
    assign r_diff  = r_shift - {1'b0, dsr_in};
    assign r_d     = r_diff[DATA_W] ? r_shift[DATA_W-1:0] : r_diff[DATA_W-1:0];

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= r_d;
        dvd_q[k]  <= {dvd_in[DATA_W-2:0], 1'b0};
        dsr_q[k]  <= dsr_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign rem_o   = rem_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

  // A finished remainder is always below a nonzero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NSTG-1] && (dsr_q[NSTG-1] != '0)) |-> (rem_q[NSTG-1] < dsr_q[NSTG-1]))
    else $error("remainder not below divisor");

endmodule

// ===== hw/rtl/rrcw_frac_div.sv =====
// ----------------------------------------------------------------------------
// Fraction divider
// Pipelined restoring division, one quotient bit per stage, that turns the
// offset into the input range into a fraction of the span.
// ----------------------------------------------------------------------------
module rrcw_frac_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rrcw_pkg::NUM_W-1:0]     numer_i,
  input  logic [rrcw_pkg::DATA_W-1:0]    divisor_i,
  input  rrcw_pkg::frac_side_t           side_i,
  output logic                           valid_o,
  output logic [rrcw_pkg::Q_W-1:0]       quot_o,
  output rrcw_pkg::frac_side_t           side_o
);
  import rrcw_pkg::*;

  localparam int unsigned NSTG = Q_W;

  logic              valid_q [NSTG];
  logic [DATA_W-1:0] rem_q   [NSTG];
  logic [Q_W-1:0]    low_q   [NSTG];
  logic [Q_W-1:0]    quot_q  [NSTG];
  logic [DATA_W-1:0] dsr_q   [NSTG];
  frac_side_t        side_q  [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic              v_in;
    logic [DATA_W-1:0] r_in;
    logic [Q_W-1:0]    low_in;
    logic [Q_W-1:0]    quot_in;
    logic [DATA_W-1:0] dsr_in;
    frac_side_t        s_in;
    logic [DATA_W:0]   r_shift;
    logic [DATA_W:0]   r_diff;
    logic [DATA_W-1:0] r_d;

    // The upper numerator bits are already below the divisor, so they seed
    // the partial remainder and only the low bits produce quotient bits.
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign r_in    = numer_i[NUM_W-1:Q_W];
      assign low_in  = numer_i[Q_W-1:0];
      assign quot_in = '0;
      assign dsr_in  = divisor_i;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign r_in    = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quot_in = quot_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign s_in    = side_q[k-1];
    end

    // One restoring step.
    assign r_shift = {r_in, low_in[Q_W-1]};
    assign r_diff  = r_shift - {1'b0, dsr_in};
    assign r_d     = r_diff[DATA_W] ? r_shift[DATA_W-1:0] : r_diff[DATA_W-1:0];

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= r_d;
        low_q[k]  <= {low_in[Q_W-2:0], 1'b0};
        quot_q[k] <= {quot_in[Q_W-2:0], ~r_diff[DATA_W]};
        dsr_q[k]  <= dsr_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign quot_o  = quot_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

  // For a value inside a proper input range the fraction never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.below && !side_o.above && !side_o.span_zero)
      |-> (quot_o <= FRAC_ONE))
    else $error("fraction above one for an in-range value");

endmodule

// ===== hw/rtl/rrcw_out_buf.sv =====
// ----------------------------------------------------------------------------
// Output buffer
// Output register with one skid entry, so the pipeline keeps taking items
// while a finished result waits and its enable stays registered.
// ----------------------------------------------------------------------------
module rrcw_out_buf (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [rrcw_pkg::DATA_W-1:0]    data_i,
  output logic                           ready_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [rrcw_pkg::DATA_W-1:0]    m_data_o
);
  import rrcw_pkg::*;

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic [DATA_W-1:0] main_q, main_d;
  logic [DATA_W-1:0] skid_q, skid_d;
  logic              take;

  assign take = main_valid_q && m_ready_i;

  // Refill the output register from the skid entry first, then from the pipe.
  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!main_valid_q || take) begin
      main_valid_d = skid_valid_q || valid_i;
      main_d       = skid_valid_q ? skid_q : data_i;
      skid_valid_d = 1'b0;
    end else if (valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  // Occupancy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result data.
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o   = !skid_valid_q;
  assign m_valid_o = main_valid_q;
  assign m_data_o  = main_q;

  // The skid entry is only ever used behind a held output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry filled while output register empty");

  // The pipeline never delivers into a full buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !skid_valid_q)
    else $error("item delivered into full output buffer");

endmodule

// ===== hw/rtl/range_remap_clamp_wrap_unit.sv =====
// Data are signed Q16.16 fixed point.
// Throughput: one item per cycle unless the output stalls; a 32-stage remainder divider and a
// (FRAC_BITS + 1)-stage fraction divider set the depth, not the rate.
// Output stalls freeze the whole pipeline as soon as the skid entry fills.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the
// register defaults: input and output ranges 0..1.0, mode 0, hold off.
// ----------------------------------------------------------------------------
// Range remap, clamp and wrap unit
// Maps a signed fixed-point value from an input range onto an output range,
// with optional clamping, wrapping, reversal and hold.
// ----------------------------------------------------------------------------
module range_remap_clamp_wrap_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [rrcw_pkg::DATA_W-1:0]       s_axis_tdata_i,  // [31:0] value
  input  logic [1:0]                        s_axis_tuser_i,  // [0] op, [1] is_number
  // Result items.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [rrcw_pkg::DATA_W-1:0]       m_axis_tdata_o,  // [31:0] result_value
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrcw_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  logic [rrcw_pkg::DATA_W-1:0]       cfg_data_i
);
  import rrcw_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0] min_in_q, max_in_q, min_out_q, max_out_q;
  logic [MODE_W-1:0]        mode_q;
  logic                     hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_in_q  <= '0;
      max_in_q  <= DATA_W'(32'sd65536);
      min_out_q <= '0;
      max_out_q <= DATA_W'(32'sd65536);
      mode_q    <= '0;
      hold_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MIN_IN:  min_in_q  <= cfg_data_i;
        REG_MAX_IN:  max_in_q  <= cfg_data_i;
        REG_MIN_OUT: min_out_q <= cfg_data_i;
        REG_MAX_OUT: max_out_q <= cfg_data_i;
        REG_MODE:    mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_HOLD:    hold_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline enable comes from the registered output buffer state.
  logic en;
  logic buf_ready;

  assign en              = buf_ready;
  assign s_axis_tready_o = en;

  // Stage 1: capture the item and pick the ranges for its direction.
  logic                     s1_valid_q;
  logic                     s1_is_num_q;
  logic signed [DATA_W-1:0] s1_v_q, s1_lo_q, s1_hi_q, s1_lo_out_q, s1_hi_out_q;

  // Stage 2: span, equal output bounds and clamping.
  logic                     s2_valid_q;
  logic                     s2_is_num_q, s2_eq_out_q;
  logic signed [DATA_W-1:0] s2_v1_q, s2_lo_q, s2_hi_q, s2_lo_out_q, s2_hi_out_q;
  logic signed [SPAN_W-1:0] s2_span_q;
  logic signed [SPAN_W-1:0] span_d;
  logic signed [DATA_W-1:0] v1_d;

  assign span_d = {s1_hi_q[DATA_W-1], s1_hi_q} - {s1_lo_q[DATA_W-1], s1_lo_q};

  always_comb begin
    v1_d = s1_v_q;
    if ((s1_v_q < s1_lo_q) && mode_q[MODE_CLAMP_LO]) begin
      v1_d = s1_lo_q;
    end else if ((s1_v_q > s1_hi_q) && mode_q[MODE_CLAMP_HI]) begin
      v1_d = s1_hi_q;
    end
  end

  // Stage 3 logic: wrap decision and magnitudes for the remainder divider.
  rem_side_t                rem_side_in, rem_side_out;
  logic [DATA_W-1:0]        abs_v, abs_span, rem_out;
  logic signed [SPAN_W-1:0] neg_span;
  logic                     rem_valid;

  assign neg_span = -s2_span_q;
  assign abs_v    = s2_v1_q[DATA_W-1] ? (DATA_W'(0) - s2_v1_q) : s2_v1_q;
  assign abs_span = s2_span_q[SPAN_W-1] ? neg_span[DATA_W-1:0] : s2_span_q[DATA_W-1:0];

  always_comb begin
    rem_side_in.is_num    = s2_is_num_q;
    rem_side_in.eq_out    = s2_eq_out_q;
    rem_side_in.neg_v     = s2_v1_q[DATA_W-1];
    rem_side_in.need_wrap = ((s2_v1_q < s2_lo_q) || (s2_v1_q > s2_hi_q))
                            && mode_q[MODE_WRAP] && (s2_span_q != '0);
    rem_side_in.v1        = s2_v1_q;
    rem_side_in.lo        = s2_lo_q;
    rem_side_in.hi        = s2_hi_q;
    rem_side_in.lo_out    = s2_lo_out_q;
    rem_side_in.hi_out    = s2_hi_out_q;
    rem_side_in.span      = s2_span_q;
  end

  rrcw_rem_div u_rem_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s2_valid_q),
    .dividend_i (abs_v),
    .divisor_i  (abs_span),
    .side_i     (rem_side_in),
    .valid_o    (rem_valid),
    .rem_o      (rem_out),
    .side_o     (rem_side_out)
  );

  // Stage 4: signed remainder plus the lower bound.
  logic                       s4_valid_q;
  logic signed [DATA_W+1:0]   s4_w_q, w_d;
  rem_side_t                  s4_side_q;
  logic signed [DATA_W+1:0]   lo_ext4, rem_ext;

  assign lo_ext4 = {{2{rem_side_out.lo[DATA_W-1]}}, rem_side_out.lo};
  assign rem_ext = {2'b00, rem_out};
  assign w_d     = rem_side_out.neg_v ? (lo_ext4 - rem_ext) : (lo_ext4 + rem_ext);

  // Stage 5: the magnitude of that sum when wrapping, else the clamped value.
  logic                       s5_valid_q;
  logic signed [DATA_W+2:0]   s5_v2_q, v2_d;
  rem_side_t                  s5_side_q;
  logic signed [DATA_W+2:0]   w_ext;

  assign w_ext = {s4_w_q[DATA_W+1], s4_w_q};
  assign v2_d  = s4_side_q.need_wrap ? (w_ext[DATA_W+2] ? -w_ext : w_ext)
                                     : {{3{s4_side_q.v1[DATA_W-1]}}, s4_side_q.v1};

  // Stage 6: range tests and the offset into the range.
  logic                     s6_valid_q;
  logic [DATA_W-1:0]        s6_num_q;
  logic signed [SPAN_W-1:0] s6_span_q;
  frac_side_t               s6_side_q, frac_side_d;
  logic signed [DATA_W+2:0] lo_ext6, hi_ext6, num_full;

  assign lo_ext6  = {{3{s5_side_q.lo[DATA_W-1]}}, s5_side_q.lo};
  assign hi_ext6  = {{3{s5_side_q.hi[DATA_W-1]}}, s5_side_q.hi};
  assign num_full = s5_v2_q - lo_ext6;

  always_comb begin
    frac_side_d.is_num    = s5_side_q.is_num;
    frac_side_d.eq_out    = s5_side_q.eq_out;
    frac_side_d.below     = s5_v2_q < lo_ext6;
    frac_side_d.above     = s5_v2_q > hi_ext6;
    frac_side_d.span_zero = s5_side_q.span == '0;
    frac_side_d.num_pos   = s5_v2_q > lo_ext6;
    frac_side_d.lo_out    = s5_side_q.lo_out;
    frac_side_d.hi_out    = s5_side_q.hi_out;
  end

  // Stage 7 logic: scaled offset plus half the span, rounding the fraction.
  logic [NUM_W-1:0] numer;
  logic [Q_W-1:0]   quot;
  frac_side_t       frac_side_out;
  logic             frac_valid;

  assign numer = {1'b0, s6_num_q, {FRAC_BITS{1'b0}}}
               + {{(NUM_W-DATA_W){1'b0}}, s6_span_q[DATA_W:1]};

  rrcw_frac_div u_frac_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s6_valid_q),
    .numer_i   (numer),
    .divisor_i (s6_span_q[DATA_W-1:0]),
    .side_i    (s6_side_q),
    .valid_o   (frac_valid),
    .quot_o    (quot),
    .side_o    (frac_side_out)
  );

  // Stage 8: limit, reverse or hold the fraction; output span.
  logic                     s8_valid_q;
  logic [Q_W-1:0]           s8_p_q, p_lim, p_d;
  logic signed [SPAN_W-1:0] s8_diff_q;
  frac_side_t               s8_side_q;

  assign p_lim = (quot > FRAC_ONE) ? FRAC_ONE : quot;

  always_comb begin
    p_d = p_lim;
    if (mode_q[MODE_REVERSE]) begin
      p_d = FRAC_ONE - p_lim;
    end else if (hold_q) begin
      p_d = frac_side_out.num_pos ? FRAC_ONE : '0;
    end
  end

  // Stage 9: blend product.
  logic                     s9_valid_q;
  logic signed [PROD_W-1:0] s9_prod_q;
  frac_side_t               s9_side_q;
  logic signed [Q_W:0]      p_s;

  assign p_s = {1'b0, s8_p_q};

  // Stage 10: add the rounding half.
  localparam logic signed [PROD_W-1:0] PROD_HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic                     s10_valid_q;
  logic signed [PROD_W-1:0] s10_t_q;
  frac_side_t               s10_side_q;

  // Stage 11: floor shift and offset by the lower output bound.
  logic                     s11_valid_q;
  logic signed [RES_W-1:0]  s11_r_q, r_d;
  frac_side_t               s11_side_q;
  logic signed [SH_W-1:0]   t_sh;

  assign t_sh = s10_t_q[PROD_W-1:FRAC_BITS];
  assign r_d  = {{(RES_W-DATA_W){s10_side_q.lo_out[DATA_W-1]}}, s10_side_q.lo_out}
              + {t_sh[SH_W-1], t_sh};

  // Final select: saturation and the special cases.
  logic [DATA_W-1:0] sat_res, res_d;
  logic              ovf_hi, ovf_lo;

  assign ovf_hi = !s11_r_q[RES_W-1] && (|s11_r_q[RES_W-2:DATA_W-1]);
  assign ovf_lo = s11_r_q[RES_W-1] && !(&s11_r_q[RES_W-2:DATA_W-1]);

  always_comb begin
    sat_res = s11_r_q[DATA_W-1:0];
    if (ovf_hi) begin
      sat_res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (ovf_lo) begin
      sat_res = {1'b1, {(DATA_W-1){1'b0}}};
    end
    if (!s11_side_q.is_num) begin
      res_d = '0;
    end else if (s11_side_q.eq_out || s11_side_q.below) begin
      res_d = s11_side_q.lo_out;
    end else if (s11_side_q.above) begin
      res_d = s11_side_q.hi_out;
    end else if (s11_side_q.span_zero) begin
      res_d = s11_side_q.lo_out;
    end else begin
      res_d = sat_res;
    end
  end

  // Valid bits of the top-level stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
      s11_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= s_axis_tvalid_i;
      s2_valid_q  <= s1_valid_q;
      s4_valid_q  <= rem_valid;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s8_valid_q  <= frac_valid;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
      s11_valid_q <= s10_valid_q;
    end
  end

  // Payload of the top-level stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_is_num_q <= s_axis_tuser_i[1];
      s1_v_q      <= s_axis_tdata_i;
      s1_lo_q     <= s_axis_tuser_i[0] ? min_out_q : min_in_q;
      s1_hi_q     <= s_axis_tuser_i[0] ? max_out_q : max_in_q;
      s1_lo_out_q <= s_axis_tuser_i[0] ? min_in_q : min_out_q;
      s1_hi_out_q <= s_axis_tuser_i[0] ? max_in_q : max_out_q;

      s2_is_num_q <= s1_is_num_q;
      s2_eq_out_q <= s1_lo_out_q == s1_hi_out_q;
      s2_v1_q     <= v1_d;
      s2_lo_q     <= s1_lo_q;
      s2_hi_q     <= s1_hi_q;
      s2_lo_out_q <= s1_lo_out_q;
      s2_hi_out_q <= s1_hi_out_q;
      s2_span_q   <= span_d;

      s4_w_q      <= w_d;
      s4_side_q   <= rem_side_out;

      s5_v2_q     <= v2_d;
      s5_side_q   <= s4_side_q;

      s6_num_q    <= num_full[DATA_W-1:0];
      s6_span_q   <= s5_side_q.span;
      s6_side_q   <= frac_side_d;

      s8_p_q      <= p_d;
      s8_diff_q   <= {frac_side_out.hi_out[DATA_W-1], frac_side_out.hi_out}
                   - {frac_side_out.lo_out[DATA_W-1], frac_side_out.lo_out};
      s8_side_q   <= frac_side_out;

      s9_prod_q   <= p_s * s8_diff_q;
      s9_side_q   <= s8_side_q;

      s10_t_q     <= s9_prod_q + PROD_HALF;
      s10_side_q  <= s9_side_q;

      s11_r_q     <= r_d;
      s11_side_q  <= s10_side_q;
    end
  end

  // Output register with skid entry.
  rrcw_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s11_valid_q && en),
    .data_i    (res_d),
    .ready_o   (buf_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

  // A stalled pipeline keeps its last stage occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && s11_valid_q) |=> s11_valid_q)
    else $error("last stage item lost during stall");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range remap unit testbench
// Drives value items through the remap pipeline under several register
// settings and random flow control on both streams. An in-bench model
// predicts each result, and a monitor compares results in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import rrcw_pkg::*;

  // Register indexes past the end of the list; writes to them are ignored.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned PIPE_DRAIN = 80;
  localparam longint unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_STALL = 1500;
  localparam int unsigned BATCH_ITEMS = 47;
  localparam int unsigned STALL_BATCH_ITEMS = 120;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        op;
    logic        is_num;
    logic [31:0] value;
  } value_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [DATA_W-1:0] s_axis_tdata_i = '0;  // [31:0] value
  logic [1:0] s_axis_tuser_i = '0;         // [0] op, [1] is_number
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata_o;       // [31:0] result_value
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  range_remap_clamp_wrap_unit uut (.*);

  // Shadow copy of the registers, same reset values as the block.
  logic [31:0] min_in_q = 32'd0, max_in_q = 32'd65536;
  logic [31:0] min_out_q = 32'd0, max_out_q = 32'd65536;
  logic [3:0] mode_q = 4'd0;
  logic hold_q = 1'b0;

  value_item_t pending_items[$];
  logic [31:0] expected_results[$];
  int unsigned src_idle_pct = 0, snk_idle_pct = 0;
  bit src_hold = 0, long_stall_go = 0, long_stall_ran = 0;
  bit item_taken = 0;
  int unsigned stall_count = 0, errors = 0, results_seen = 0, items_sent = 0;
  longint unsigned cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Linear remap with clamp, wrap, reverse and hold, at 64-bit precision.
  function automatic logic [31:0] remap_value(longint v, longint lo, longint hi,
                                              longint lo_o, longint hi_o);
    longint span, num, prod, w;
    longint unsigned frac;
    longint one;
    span = hi - lo;
    one = 64'sd1 <<< FRAC_BITS;
    if (lo_o == hi_o) return 32'(clip32(lo_o));
    if (v < lo && mode_q[MODE_CLAMP_LO]) v = lo;
    else if (v > hi && mode_q[MODE_CLAMP_HI]) v = hi;
    // Wrap keeps the sign of the value in the remainder, then folds to positive.
    if ((v < lo || v > hi) && mode_q[MODE_WRAP] && span != 0) begin
      w = (v % span) + lo;
      v = (w < 0) ? -w : w;
    end
    if (v < lo) return 32'(clip32(lo_o));
    if (v > hi) return 32'(clip32(hi_o));
    if (span == 0) return 32'(clip32(lo_o));
    num = v - lo;
    frac = ((longint'(num) << FRAC_BITS) + longint'(span) / 2) / span;
    if (frac > one) frac = one;
    if (mode_q[MODE_REVERSE]) frac = one - frac;
    else if (hold_q) frac = (num > 0) ? one : 0;
    prod = longint'(frac) * (hi_o - lo_o) + (one >>> 1);
    return 32'(clip32(lo_o + (prod >>> FRAC_BITS)));
  endfunction

  function automatic logic [31:0] predict_result(value_item_t it);
    longint a, b, c, d, v;
    a = longint'(signed'(min_in_q));
    b = longint'(signed'(max_in_q));
    c = longint'(signed'(min_out_q));
    d = longint'(signed'(max_out_q));
    v = longint'(signed'(it.value));
    if (!it.is_num) return 32'd0;
    if (it.op) return remap_value(v, c, d, a, b);
    return remap_value(v, a, b, c, d);
  endfunction

  // Source side: hold an offered item until it is taken, idle between items.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid_i && !item_taken)) begin
      if (pending_items.size() > 0 && !src_hold &&
          $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= pending_items[0].value;
        s_axis_tuser_i <= {pending_items[0].is_num, pending_items[0].op};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    item_taken = 0;
  end

  // Sink side: random back-pressure plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (long_stall_go && !long_stall_ran) begin
      m_axis_tready_i <= 1'b0;
      stall_count = stall_count + 1;
      if (stall_count >= LONG_STALL) long_stall_ran = 1;
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Accepted inputs become expectations; accepted results are checked.
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_results.push_back(predict_result(pending_items.pop_front()));
      items_sent++;
      item_taken = 1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result_value: nothing expected, actual %0d", $signed(m_axis_tdata_o));
        errors++;
      end else begin
        logic [31:0] want;
        want = expected_results.pop_front();
        if (want !== m_axis_tdata_o) begin
          $error("result_value: expected %0d, actual %0d", $signed(want),
                 $signed(m_axis_tdata_o));
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MIN_IN:  min_in_q = data;
      REG_MAX_IN:  max_in_q = data;
      REG_MIN_OUT: min_out_q = data;
      REG_MAX_OUT: max_out_q = data;
      REG_MODE:    mode_q = data[3:0];
      REG_HOLD:    hold_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(5))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic value_item_t make_item();
    value_item_t it;
    logic [31:0] lo, hi;
    it.op = $urandom_range(1);
    it.is_num = ($urandom_range(15) != 0);
    lo = it.op ? min_out_q : min_in_q;
    hi = it.op ? max_out_q : max_in_q;
    case ($urandom_range(6))
      0: it.value = $urandom;
      1: it.value = lo + 32'($signed($urandom_range(64)) - 32);
      2: it.value = hi + 32'($signed($urandom_range(64)) - 32);
      3: it.value = lo + ((hi - lo) >> 1) + 32'($signed($urandom_range(2000)) - 1000);
      4: it.value = $urandom_range(1) ? S_MIN : S_MAX;
      default: it.value = lo + $urandom_range(hi - lo);
    endcase
    return it;
  endfunction

  task automatic queue_item(logic op, logic is_num, logic [31:0] v);
    value_item_t it;
    it.op = op;
    it.is_num = is_num;
    it.value = v;
    pending_items.push_back(it);
  endtask

  task automatic random_settings(int k);
    write_reg(REG_MIN_IN, pick_bound());
    write_reg(REG_MAX_IN, ($urandom_range(3) == 0) ? min_in_q : pick_bound());
    write_reg(REG_MIN_OUT, pick_bound());
    write_reg(REG_MAX_OUT, ($urandom_range(7) == 0) ? min_out_q : pick_bound());
    write_reg(REG_MODE, 32'(k % 16) | ($urandom << 4));
    write_reg(REG_HOLD, $urandom);
  endtask

  initial begin
    int unsigned n_settings;
    int unsigned batch_len;
    n_settings = 14;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 37;
    snk_idle_pct = 77;

    // Directed items under the reset settings: extremes, both directions,
    // two non-numbers, bounds and just outside them.
    queue_item(1'b0, 1'b1, 32'd0);
    queue_item(1'b0, 1'b1, 32'd65536);
    queue_item(1'b0, 1'b1, 32'd32768);
    queue_item(1'b0, 1'b1, S_MAX);
    queue_item(1'b0, 1'b1, S_MIN);
    queue_item(1'b0, 1'b1, 32'hffff_ffff);
    queue_item(1'b0, 1'b1, 32'd65537);
    queue_item(1'b1, 1'b1, 32'd12345);
    queue_item(1'b0, 1'b0, 32'd777);
    queue_item(1'b1, 1'b0, S_MIN);
    drain();

    // Extreme ranges with both clamps and wrap on, plus the spare indexes.
    write_reg(REG_MIN_IN, S_MIN);
    write_reg(REG_MAX_IN, S_MAX);
    write_reg(REG_MIN_OUT, S_MAX);
    write_reg(REG_MAX_OUT, S_MIN);
    write_reg(REG_MODE, 32'hffff_fff7);
    write_reg(REG_HOLD, 32'hffff_ffff);
    write_reg(REG_SPARE_A, 32'h1234_5678);
    write_reg(REG_SPARE_B, 32'hffff_ffff);
    queue_item(1'b0, 1'b1, S_MIN);
    queue_item(1'b0, 1'b1, S_MAX);
    queue_item(1'b0, 1'b1, 32'd0);
    queue_item(1'b1, 1'b1, S_MAX);
    queue_item(1'b1, 1'b1, 32'd1);
    drain();
    // Inverted input range with wrap, and a zero-width input range.
    write_reg(REG_MIN_IN, 32'd3 << 16);
    write_reg(REG_MAX_IN, 32'hfffd_0000);
    write_reg(REG_MODE, 32'd4);
    queue_item(1'b0, 1'b1, 32'd7 << 16);
    queue_item(1'b0, 1'b1, 32'hfff0_0000);
    drain();
    write_reg(REG_MAX_IN, 32'd3 << 16);
    write_reg(REG_MODE, 32'd0);
    queue_item(1'b0, 1'b1, 32'd3 << 16);
    queue_item(1'b0, 1'b1, 32'd5 << 16);
    drain();

    // Random settings, each followed by a batch of random items. The batch
    // under the long output hold-off is longer than the pipeline, so the
    // block fills up and stalls its input.
    for (int k = 0; k < n_settings; k++) begin
      if (k == n_settings / 3) begin
        src_idle_pct = 77;
        snk_idle_pct = 37;
      end else if (k == 2 * n_settings / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_settings(k);
      if (k == n_settings - 2) long_stall_go = 1;
      batch_len = (k == n_settings - 2) ? STALL_BATCH_ITEMS : BATCH_ITEMS;
      for (int j = 0; j < batch_len; j++) begin
        pending_items.push_back(make_item());
        if (k == 3 && j == 25) begin
          src_hold = 1;
          wait (expected_results.size() == 0);
          src_hold = 0;
        end
      end
      drain();
    end

    $display("Covered %0d items, %0d results, %0d register settings with mode values 0 to 13,",
             items_sent, results_seen, n_settings + 4);
    $display("random idling on both streams, one long output hold-off and one source pause.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
